// ----- rtl/core/fpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpcr_pkg
// Types, codes and defaults shared by the false-position cubic root finder.
// ----------------------------------------------------------------------------
package fpcr_pkg;

   localparam int FRAC_BITS_DEFAULT     = 16;
   localparam int MAX_ITER_BITS_DEFAULT = 8;
   localparam int CSR_ADDR_W            = 5;

   typedef enum logic [2:0] {
      REG_COEF_CUBIC  = 3'd0,
      REG_COEF_SQUARE = 3'd1,
      REG_COEF_LINEAR = 3'd2,
      REG_COEF_CONST  = 3'd3,
      REG_TOLERANCE   = 3'd4,
      REG_ITER_LIMIT  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      OUTCOME_ZERO  = 2'd0,
      OUTCOME_TOL   = 2'd1,
      OUTCOME_LIMIT = 2'd2,
      OUTCOME_DEN   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      PHASE_FA,
      PHASE_FB,
      PHASE_FC
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SEC_P1,
      ST_SEC_P2,
      ST_SEC_SUB,
      ST_SEC_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] coef_cubic;
      logic signed [31:0] coef_square;
      logic signed [31:0] coef_linear;
      logic signed [31:0] coef_const;
      logic [30:0]        tolerance;
      logic [7:0]         iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] left_end;
      logic signed [31:0] right_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root_estimate;
      logic [7:0]         iterations_used;
      logic [1:0]         outcome;
      logic               saturated;
   } rsp_type;

endpackage

// ----- rtl/core/fpcr_csr.sv -----
// ----------------------------------------------------------------------------
// fpcr_csr
// Configuration registers: polynomial coefficients, tolerance and limit.
// ----------------------------------------------------------------------------
module fpcr_csr
   import fpcr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
   localparam logic [63:0] SQ64  = 64'd0 - (64'd5 << FRAC_BITS);
   localparam logic [63:0] LIN64 = 64'd11 << FRAC_BITS;
   localparam logic [63:0] CON64 = 64'd0 - (64'd6 << FRAC_BITS);
   localparam logic [63:0] TOL64 = (ONE64 + 64'd5000) / 64'd10000;

   cfg_type cfg_ff;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_cubic      <= ONE64[31:0];
         cfg_ff.coef_square     <= SQ64[31:0];
         cfg_ff.coef_linear     <= LIN64[31:0];
         cfg_ff.coef_const      <= CON64[31:0];
         cfg_ff.tolerance       <= TOL64[30:0];
         cfg_ff.iteration_limit <= 8'd64;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            REG_COEF_CUBIC:  cfg_ff.coef_cubic      <= pwdata;
            REG_COEF_SQUARE: cfg_ff.coef_square     <= pwdata;
            REG_COEF_LINEAR: cfg_ff.coef_linear     <= pwdata;
            REG_COEF_CONST:  cfg_ff.coef_const      <= pwdata;
            REG_TOLERANCE:   cfg_ff.tolerance       <= pwdata[30:0];
            REG_ITER_LIMIT:  cfg_ff.iteration_limit <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_COEF_CUBIC:  prdata = cfg_ff.coef_cubic;
         REG_COEF_SQUARE: prdata = cfg_ff.coef_square;
         REG_COEF_LINEAR: prdata = cfg_ff.coef_linear;
         REG_COEF_CONST:  prdata = cfg_ff.coef_const;
         REG_TOLERANCE:   prdata = {1'b0, cfg_ff.tolerance};
         REG_ITER_LIMIT:  prdata = {24'd0, cfg_ff.iteration_limit};
         default:         prdata = 32'd0;
      endcase
   end

endmodule

// ----- rtl/core/fpcr_mul.sv -----
// ----------------------------------------------------------------------------
// fpcr_mul
// Shared signed 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fpcr_mul
   import fpcr_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/core/fpcr_div.sv -----
// ----------------------------------------------------------------------------
// fpcr_div
// Restoring divider, 64-bit unsigned numerator by 33-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpcr_div
   import fpcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] trial;
   logic [33:0] diff;

   assign trial = {rem_ff, quo_ff[63]};
   assign diff  = trial - {1'b0, den_ff};
   assign done  = done_ff;
   assign quo   = quo_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'd0;
         rem_in = 33'd0;
         quo_in = num;
         den_in = den;
      end else if (run_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

// ----- rtl/core/false_position_cubic_root.sv -----
// ----------------------------------------------------------------------------
// false_position_cubic_root
// Finds a root of a cubic in signed fixed point by false position, with one
// shared multiplier and a serial divider under a sequencer.
//
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_data  (req_type)
// rsp       out        rsp_valid/rsp_stall rsp_data  (rsp_type)
// csr       in         psel/penable        paddr, pwdata, prdata
//
// Each polynomial evaluation is a chain of multiply-add steps by Horner's rule
// on the multiplier. Each iteration needs three evaluations, the secant point,
// found from the cross products, a subtraction and the 64-step divider, and
// the end check; iterations go on up to the iteration limit.
// Reset is synchronous and restores the coefficient defaults.
// A new request is taken only while the sequencer is idle; a finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module false_position_cubic_root
   import fpcr_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEFAULT,
   parameter int MAX_ITER_BITS = MAX_ITER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IB = MAX_ITER_BITS;

   cfg_type cfg;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [31:0] x_ff, x_in, acc_ff, acc_in;
   logic signed [31:0] fa_ff, fa_in, fb_ff, fb_in;
   logic signed [63:0] p1_ff, p1_in;
   logic [1:0]         step_ff, step_in;
   logic [IB-1:0]      iter_ff, iter_in, limit_ff, limit_in;
   logic               sat_ff, sat_in;
   logic               neg_ff, neg_in;
   outcome_type        outcome_ff, outcome_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic signed [64:0] prod_ext, hsum;
   logic signed [31:0] coef_sel, hres;
   logic               hovf;
   logic signed [64:0] num_s;
   logic signed [32:0] den_s;
   logic [63:0]        num_mag;
   logic [32:0]        den_mag;
   logic               div_start, div_done;
   logic [63:0]        quo;
   logic signed [31:0] cres;
   logic               covf;
   logic signed [32:0] width_s;
   logic [32:0]        width_mag;
   logic [IB+7:0]      lim_wide, cap_wide, iter_wide;

   fpcr_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
      .pready, .cfg
   );

   fpcr_mul u_mul (.clock, .op_a(mul_a), .op_b(mul_b), .prod);

   fpcr_div u_div (
      .clock, .reset, .start(div_start), .num(num_mag), .den(den_mag),
      .done(div_done), .quo
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      unique case (state_ff)
         ST_SEC_P1: begin
            mul_a = a_ff;
            mul_b = fb_ff;
         end
         ST_SEC_P2: begin
            mul_a = b_ff;
            mul_b = fa_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = x_ff;
         end
      endcase
   end

   always_comb begin
      case (step_ff)
         2'd0:    coef_sel = cfg.coef_square;
         2'd1:    coef_sel = cfg.coef_linear;
         default: coef_sel = cfg.coef_const;
      endcase
   end

   assign prod_ext = {prod[63], prod};
   assign hsum     = (prod_ext >>> FRAC_BITS) + $signed({{33{coef_sel[31]}}, coef_sel});
   assign hovf     = !((&hsum[64:31]) || !(|hsum[64:31]));
   assign hres     = hovf ? (hsum[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : hsum[31:0];

   assign num_s     = {p1_ff[63], p1_ff} - {prod[63], prod};
   assign den_s     = {fb_ff[31], fb_ff} - {fa_ff[31], fa_ff};
   assign num_mag   = num_s[64] ? 64'(-num_s) : num_s[63:0];
   assign den_mag   = den_s[32] ? 33'(-den_s) : den_s;
   assign div_start = (state_ff == ST_SEC_SUB);

   always_comb begin
      covf = 1'b0;
      cres = quo[31:0];
      if (neg_ff) begin
         if (quo > 64'h8000_0000) begin
            covf = 1'b1;
            cres = 32'sh8000_0000;
         end else begin
            cres = 32'(-quo[31:0]);
         end
      end else if (quo > 64'h7FFF_FFFF) begin
         covf = 1'b1;
         cres = 32'sh7FFF_FFFF;
      end
   end

   assign width_s   = {b_ff[31], b_ff} - {a_ff[31], a_ff};
   assign width_mag = width_s[32] ? 33'(-width_s) : width_s;

   assign lim_wide  = {{IB{1'b0}}, cfg.iteration_limit};
   assign cap_wide  = {8'd0, {IB{1'b1}}};
   assign iter_wide = {8'd0, iter_ff};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      p1_in        = p1_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      limit_in     = limit_ff;
      sat_in       = sat_ff;
      neg_in       = neg_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_data.left_end;
               b_in     = req_data.right_end;
               c_in     = req_data.left_end;
               x_in     = req_data.left_end;
               acc_in   = cfg.coef_cubic;
               step_in  = 2'd0;
               phase_in = PHASE_FA;
               iter_in  = '0;
               sat_in   = 1'b0;
               if (cfg.iteration_limit == 8'd0) begin
                  limit_in = IB'(1);
               end else if (lim_wide > cap_wide) begin
                  limit_in = {IB{1'b1}};
               end else begin
                  limit_in = lim_wide[IB-1:0];
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in  = hres;
            sat_in  = sat_ff | hovf;
            step_in = step_ff + 2'd1;
            state_in = ST_MUL;
            if (step_ff == 2'd2) begin
               step_in = 2'd0;
               acc_in  = cfg.coef_cubic;
               unique case (phase_ff)
                  PHASE_FA: begin
                     fa_in    = hres;
                     x_in     = b_ff;
                     phase_in = PHASE_FB;
                  end
                  PHASE_FB: begin
                     fb_in = hres;
                     if (hres == fa_ff) begin
                        outcome_in = OUTCOME_DEN;
                        state_in   = ST_DONE;
                     end else begin
                        state_in = ST_SEC_P1;
                     end
                  end
                  default: begin
                     iter_in = iter_ff + IB'(1);
                     if (hres == 32'sd0) begin
                        outcome_in = OUTCOME_ZERO;
                        state_in   = ST_DONE;
                     end else begin
                        if (fa_ff != 32'sd0 && (hres[31] != fa_ff[31])) begin
                           b_in = c_ff;
                        end else begin
                           a_in = c_ff;
                        end
                        state_in = ST_CHECK;
                     end
                  end
               endcase
            end
         end
         ST_SEC_P1: begin
            state_in = ST_SEC_P2;
         end
         ST_SEC_P2: begin
            p1_in    = prod;
            state_in = ST_SEC_SUB;
         end
         ST_SEC_SUB: begin
            neg_in   = num_s[64] ^ den_s[32];
            state_in = ST_SEC_DIV;
         end
         ST_SEC_DIV: begin
            if (div_done) begin
               c_in     = cres;
               x_in     = cres;
               sat_in   = sat_ff | covf;
               acc_in   = cfg.coef_cubic;
               step_in  = 2'd0;
               phase_in = PHASE_FC;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            if (width_mag < {2'b00, cfg.tolerance}) begin
               outcome_in = OUTCOME_TOL;
               state_in   = ST_DONE;
            end else if (iter_ff >= limit_ff) begin
               outcome_in = OUTCOME_LIMIT;
               state_in   = ST_DONE;
            end else begin
               x_in     = a_ff;
               acc_in   = cfg.coef_cubic;
               step_in  = 2'd0;
               phase_in = PHASE_FA;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.root_estimate   = c_ff;
               rsp_in.iterations_used = iter_wide[7:0];
               rsp_in.outcome         = outcome_ff;
               rsp_in.saturated       = sat_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff   <= phase_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      x_ff       <= x_in;
      acc_ff     <= acc_in;
      fa_ff      <= fa_in;
      fb_ff      <= fb_in;
      p1_ff      <= p1_in;
      step_ff    <= step_in;
      iter_ff    <= iter_in;
      limit_ff   <= limit_in;
      sat_ff     <= sat_in;
      neg_ff     <= neg_in;
      outcome_ff <= outcome_in;
      rsp_ff     <= rsp_in;
   end

endmodule
